// File: design/wht_pkg.sv
`timescale 1ns / 1ps
// Walsh-Hadamard transform unit: shared constants, types and helper functions.
// No dependencies; used by every other file of the block.
package wht_pkg;

   localparam int MAX_LENGTH  = 2048;
   localparam int SAMPLE_BITS = 16;
   localparam int COEF_BITS   = 28;
   localparam int MIN_LOG2    = 5;
   localparam int MAX_LOG2    = $clog2(MAX_LENGTH);
   localparam int ADDR_BITS   = MAX_LOG2;
   localparam int PAIR_BITS   = ADDR_BITS - 1;
   localparam int CNT_BITS    = ADDR_BITS + 1;
   localparam int STAGE_BITS  = $clog2(MAX_LOG2 + 1);
   localparam int CFG_BITS    = 4;
   localparam int CSR_DATA_BITS = 32;
   localparam int CSR_ADDR_BITS = 3;

   localparam logic [CFG_BITS-1:0] LOG2_RESET = CFG_BITS'(8);

   localparam logic REG_LOG2_LENGTH = 1'b0;

   localparam logic ACT_PUSH = 1'b0;
   localparam logic ACT_PULL = 1'b1;

   localparam logic STATUS_VALID = 1'b0;
   localparam logic STATUS_EMPTY = 1'b1;

   typedef struct packed {
      logic                        we;
      logic [ADDR_BITS-1:0]        waddr;
      logic signed [COEF_BITS-1:0] wdata;
      logic                        re;
      logic [ADDR_BITS-1:0]        raddr_a;
      logic [ADDR_BITS-1:0]        raddr_b;
   } ram_ctl_type;

   function automatic logic [STAGE_BITS-1:0] clamp_log2(input logic [CFG_BITS-1:0] v);
      logic [STAGE_BITS-1:0] k;
      if (v < CFG_BITS'(MIN_LOG2)) begin
         k = STAGE_BITS'(MIN_LOG2);
      end else if (v > CFG_BITS'(MAX_LOG2)) begin
         k = STAGE_BITS'(MAX_LOG2);
      end else begin
         k = STAGE_BITS'(v);
      end
      return k;
   endfunction

   // lower address of a butterfly pair: a zero bit inserted at the stage position
   function automatic logic [ADDR_BITS-1:0] bfly_addr(input logic [PAIR_BITS-1:0] pair,
                                                     input logic [STAGE_BITS-1:0] stage);
      logic [ADDR_BITS-1:0] ext;
      logic [ADDR_BITS-1:0] low_mask;
      ext      = {1'b0, pair};
      low_mask = (ADDR_BITS'(1) << stage) - ADDR_BITS'(1);
      return ((ext & ~low_mask) << 1) | (ext & low_mask);
   endfunction

endpackage

// File: design/wht_if.sv
`timescale 1ns / 1ps
// Valid/ready channels of the Walsh-Hadamard transform unit: request and response words.
// Depends on wht_pkg.
interface wht_req_if;
   logic                                 valid;
   logic                                 ready;
   logic                                 action;
   logic signed [wht_pkg::SAMPLE_BITS-1:0] sample;

   modport source (output valid, action, sample, input ready);
   modport sink (input valid, action, sample, output ready);
endinterface

interface wht_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic signed [wht_pkg::COEF_BITS-1:0] coefficient;
   logic                                 last_of_row;
   logic                                 status;

   modport source (output valid, coefficient, last_of_row, status, input ready);
   modport sink (input valid, coefficient, last_of_row, status, output ready);
endinterface

// File: design/wht_row_ram.sv
`timescale 1ns / 1ps
// Row store: one write port, two registered read ports sharing one read enable.
// Depends on wht_pkg.
module wht_row_ram (
   input  logic                                 clock,
   input  wht_pkg::ram_ctl_type                 ctl,
   output logic signed [wht_pkg::COEF_BITS-1:0] rd_a,
   output logic signed [wht_pkg::COEF_BITS-1:0] rd_b
);

   logic [wht_pkg::COEF_BITS-1:0]        mem [wht_pkg::MAX_LENGTH];
   logic signed [wht_pkg::COEF_BITS-1:0] rd_a_ff;
   logic signed [wht_pkg::COEF_BITS-1:0] rd_b_ff;

   always_ff @(posedge clock) begin
      if (ctl.we) begin
         mem[ctl.waddr] <= ctl.wdata;
      end
      if (ctl.re) begin
         rd_a_ff <= mem[ctl.raddr_a];
         rd_b_ff <= mem[ctl.raddr_b];
      end
   end

   assign rd_a = rd_a_ff;
   assign rd_b = rd_b_ff;

endmodule

// File: design/walsh_hadamard_transform_unit.sv
`timescale 1ns / 1ps
// A push is accepted while idle; the push that completes a row of N = 2^k samples starts
// k stages of butterflies (per stage one read, then per pair sum and difference written back
// through one shared adder, the next read overlapping the difference write) with req.ready low.
// A pull reads the row store on acceptance and registers its word once the response register
// is free; no new request is taken before that. Reset (synchronous): counters cleared, no row
// ready, log2_length = 8; the row store contents stay undefined until written.
module walsh_hadamard_transform_unit (
   input  logic                                  clock,
   input  logic                                  reset,
   wht_req_if.sink                               req,
   wht_rsp_if.source                             rsp,
   input  logic                                  csr_psel,
   input  logic                                  csr_penable,
   input  logic                                  csr_pwrite,
   input  logic [wht_pkg::CSR_ADDR_BITS-1:0]     csr_paddr,
   input  logic [wht_pkg::CSR_DATA_BITS-1:0]     csr_pwdata,
   output logic [wht_pkg::CSR_DATA_BITS-1:0]     csr_prdata,
   output logic                                  csr_pready
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_SUM,
      ST_DIFF,
      ST_PULL
   } state_type;

   state_type                              state_ff;
   logic [wht_pkg::CNT_BITS-1:0]           fill_ff;
   logic [wht_pkg::CNT_BITS-1:0]           rptr_ff;
   logic                                   ready_ff;
   logic [wht_pkg::CFG_BITS-1:0]           log2_ff;
   logic [wht_pkg::STAGE_BITS-1:0]         stage_ff;
   logic [wht_pkg::PAIR_BITS-1:0]          pair_ff;
   logic                                   empty_ff;
   logic                                   last_ff;
   logic                                   rsp_valid_ff;
   logic signed [wht_pkg::COEF_BITS-1:0]   rsp_coef_ff;
   logic                                   rsp_last_ff;
   logic                                   rsp_status_ff;

   wht_pkg::ram_ctl_type                   ram_ctl;
   logic signed [wht_pkg::COEF_BITS-1:0]   rd_a;
   logic signed [wht_pkg::COEF_BITS-1:0]   rd_b;

   logic [wht_pkg::STAGE_BITS-1:0]         len_log2;
   logic [wht_pkg::STAGE_BITS-1:0]         stage_last;
   logic [wht_pkg::CNT_BITS-1:0]           len_cnt;
   logic [wht_pkg::CNT_BITS-1:0]           len_m1;
   logic [wht_pkg::PAIR_BITS-1:0]          pair_last;
   logic [wht_pkg::PAIR_BITS-1:0]          pair_nxt;
   logic [wht_pkg::ADDR_BITS-1:0]          half;
   logic [wht_pkg::ADDR_BITS-1:0]          ia_cur;
   logic [wht_pkg::ADDR_BITS-1:0]          ib_cur;
   logic [wht_pkg::ADDR_BITS-1:0]          ia_nxt;
   logic [wht_pkg::ADDR_BITS-1:0]          ib_nxt;
   logic                                   alu_sub;
   logic [wht_pkg::COEF_BITS-1:0]          alu_opb;
   logic signed [wht_pkg::COEF_BITS-1:0]   alu_out;
   logic signed [wht_pkg::COEF_BITS-1:0]   sample_ext;
   logic [wht_pkg::CNT_BITS-1:0]           wr_idx;
   logic                                   push_acc;
   logic                                   pull_acc;
   logic                                   pull_empty;
   logic                                   rsp_free;
   logic                                   cfg_wr;

   wht_row_ram u_ram (
      .clock (clock),
      .ctl   (ram_ctl),
      .rd_a  (rd_a),
      .rd_b  (rd_b)
   );

   assign len_log2   = wht_pkg::clamp_log2(log2_ff);
   assign stage_last = len_log2 - wht_pkg::STAGE_BITS'(1);
   assign len_cnt    = wht_pkg::CNT_BITS'(1) << len_log2;
   assign len_m1     = len_cnt - wht_pkg::CNT_BITS'(1);
   assign pair_last  = wht_pkg::PAIR_BITS'((len_cnt >> 1) - wht_pkg::CNT_BITS'(1));
   assign pair_nxt   = pair_ff + wht_pkg::PAIR_BITS'(1);
   assign half       = wht_pkg::ADDR_BITS'(1) << stage_ff;
   assign ia_cur     = wht_pkg::bfly_addr(pair_ff, stage_ff);
   assign ib_cur     = ia_cur | half;
   assign ia_nxt     = wht_pkg::bfly_addr(pair_nxt, stage_ff);
   assign ib_nxt     = ia_nxt | half;

   // shared adder: a + b in the sum step, a + ~b + 1 in the difference step
   assign alu_sub = (state_ff == ST_DIFF);
   assign alu_opb = alu_sub ? ~rd_b : rd_b;
   assign alu_out = rd_a + $signed(alu_opb) + $signed(wht_pkg::COEF_BITS'(alu_sub));

   assign sample_ext = {{(wht_pkg::COEF_BITS - wht_pkg::SAMPLE_BITS){req.sample[wht_pkg::SAMPLE_BITS-1]}},
                        req.sample};

   assign req.ready  = (state_ff == ST_IDLE);
   assign push_acc   = req.valid && req.ready && (req.action == wht_pkg::ACT_PUSH);
   assign pull_acc   = req.valid && req.ready && (req.action == wht_pkg::ACT_PULL);
   assign wr_idx     = (fill_ff >= len_cnt) ? '0 : fill_ff;
   assign pull_empty = !ready_ff || (rptr_ff >= len_cnt);
   assign rsp_free   = !rsp_valid_ff || rsp.ready;

   assign cfg_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready &&
                       (csr_paddr[2] == wht_pkg::REG_LOG2_LENGTH);
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == wht_pkg::REG_LOG2_LENGTH) ?
                       wht_pkg::CSR_DATA_BITS'(log2_ff) : '0;

   always_comb begin
      ram_ctl = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (push_acc && !ready_ff) begin
               ram_ctl.we    = 1'b1;
               ram_ctl.waddr = wr_idx[wht_pkg::ADDR_BITS-1:0];
               ram_ctl.wdata = sample_ext;
            end
            if (pull_acc) begin
               ram_ctl.re      = 1'b1;
               ram_ctl.raddr_a = rptr_ff[wht_pkg::ADDR_BITS-1:0];
               ram_ctl.raddr_b = rptr_ff[wht_pkg::ADDR_BITS-1:0];
            end
         end
         ST_READ: begin
            ram_ctl.re      = 1'b1;
            ram_ctl.raddr_a = ia_cur;
            ram_ctl.raddr_b = ib_cur;
         end
         ST_SUM: begin
            ram_ctl.we    = 1'b1;
            ram_ctl.waddr = ia_cur;
            ram_ctl.wdata = alu_out;
         end
         ST_DIFF: begin
            ram_ctl.we    = 1'b1;
            ram_ctl.waddr = ib_cur;
            ram_ctl.wdata = alu_out;
            // next pair of the same stage is disjoint, so its read overlaps this write
            if (pair_ff != pair_last) begin
               ram_ctl.re      = 1'b1;
               ram_ctl.raddr_a = ia_nxt;
               ram_ctl.raddr_b = ib_nxt;
            end
         end
         ST_PULL: begin
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         fill_ff      <= '0;
         rptr_ff      <= '0;
         ready_ff     <= 1'b0;
         log2_ff      <= wht_pkg::LOG2_RESET;
         stage_ff     <= '0;
         pair_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // the pull state reloads the word itself when the old one leaves
         if (rsp.ready && state_ff != ST_PULL) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (push_acc && !ready_ff) begin
                  if (wr_idx == len_m1) begin
                     fill_ff  <= '0;
                     rptr_ff  <= '0;
                     stage_ff <= '0;
                     pair_ff  <= '0;
                     state_ff <= ST_READ;
                  end else begin
                     fill_ff <= wr_idx + wht_pkg::CNT_BITS'(1);
                  end
               end else if (pull_acc) begin
                  empty_ff <= pull_empty;
                  last_ff  <= (rptr_ff == len_m1);
                  if (!pull_empty) begin
                     if (rptr_ff == len_m1) begin
                        rptr_ff  <= '0;
                        ready_ff <= 1'b0;
                     end else begin
                        rptr_ff <= rptr_ff + wht_pkg::CNT_BITS'(1);
                     end
                  end
                  state_ff <= ST_PULL;
               end
            end
            ST_READ: begin
               state_ff <= ST_SUM;
            end
            ST_SUM: begin
               state_ff <= ST_DIFF;
            end
            ST_DIFF: begin
               if (pair_ff != pair_last) begin
                  pair_ff  <= pair_nxt;
                  state_ff <= ST_SUM;
               end else if (stage_ff != stage_last) begin
                  stage_ff <= stage_ff + wht_pkg::STAGE_BITS'(1);
                  pair_ff  <= '0;
                  state_ff <= ST_READ;
               end else begin
                  ready_ff <= 1'b1;
                  state_ff <= ST_IDLE;
               end
            end
            ST_PULL: begin
               if (rsp_free) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_coef_ff   <= empty_ff ? '0 : rd_a;
                  rsp_last_ff   <= empty_ff ? 1'b0 : last_ff;
                  rsp_status_ff <= empty_ff ? wht_pkg::STATUS_EMPTY : wht_pkg::STATUS_VALID;
                  state_ff      <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
         if (cfg_wr) begin
            log2_ff  <= csr_pwdata[wht_pkg::CFG_BITS-1:0];
            fill_ff  <= '0;
            rptr_ff  <= '0;
            ready_ff <= 1'b0;
         end
      end
   end

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.coefficient = rsp_coef_ff;
   assign rsp.last_of_row = rsp_last_ff;
   assign rsp.status      = rsp_status_ff;

   a_ready_row_unfilled: assert property (@(posedge clock) disable iff (reset)
      ready_ff |-> (fill_ff == '0))
      else $error("row ready while samples are being collected");

   a_rptr_in_row: assert property (@(posedge clock) disable iff (reset)
      rptr_ff < len_cnt)
      else $error("read pointer past row end");

   a_fill_in_row: assert property (@(posedge clock) disable iff (reset)
      fill_ff < len_cnt)
      else $error("fill count past row end");

   a_sum_after_read: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SUM) |-> ($past(state_ff) == ST_READ || $past(state_ff) == ST_DIFF))
      else $error("sum step without a preceding read");

   a_empty_word_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && rsp.status == wht_pkg::STATUS_EMPTY) |->
         (rsp.coefficient == '0 && !rsp.last_of_row))
      else $error("empty response word carries data");

endmodule

// File: tb/sv/wht_coef_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the Walsh-Hadamard transform unit: watches both channels and the
// register port, predicts every response word and compares it. Depends on wht_pkg, wht_if.
module wht_coef_checker (
   input  logic                                clock,
   input  logic                                reset,
   wht_req_if                                  req_mon,
   wht_rsp_if                                  rsp_mon,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [wht_pkg::CSR_ADDR_BITS-1:0]   csr_paddr,
   input  logic [wht_pkg::CSR_DATA_BITS-1:0]   csr_pwdata,
   input  logic [wht_pkg::CSR_DATA_BITS-1:0]   csr_prdata,
   input  logic                                csr_pready,
   output int                                  error_count,
   output int                                  pending_words,
   output int                                  checked_words
);
   import wht_pkg::*;

   localparam int MAX_REPORTS = 40;

   typedef struct {
      logic signed [COEF_BITS-1:0] coefficient;
      logic                        last_of_row;
      logic                        status;
   } coef_word_type;

   int                  row_mem [MAX_LENGTH];
   int                  fill_cnt;
   int                  rd_ptr;
   bit                  row_done;
   logic [CFG_BITS-1:0] len_log2;
   coef_word_type       coef_q [$];
   int                  errs;
   int                  checked;

   initial begin
      errs    = 0;
      checked = 0;
   end

   function automatic int row_points();
      int k;
      k = int'(len_log2);
      if (k < MIN_LOG2) k = MIN_LOG2;
      if (k > MAX_LOG2) k = MAX_LOG2;
      return 1 << k;
   endfunction

   // in-place radix-2 butterflies, natural (Sylvester) order
   task automatic run_butterflies(input int n);
      int a;
      int b;
      for (int half = 1; half < n; half = half * 2) begin
         for (int base = 0; base < n; base = base + 2 * half) begin
            for (int i = base; i < base + half; i++) begin
               a = row_mem[i];
               b = row_mem[i + half];
               row_mem[i]        = a + b;
               row_mem[i + half] = a - b;
            end
         end
      end
   endtask

   task automatic flag(input string what, input logic signed [63:0] want_v,
                       input logic signed [63:0] got_v);
      errs++;
      if (errs <= MAX_REPORTS)
         $display("%0t ns: %s expected %0d, got %0d", $time, what, want_v, got_v);
   endtask

   always @(posedge clock) begin : watch
      int            n;
      coef_word_type want;
      if (reset) begin
         fill_cnt = 0;
         rd_ptr   = 0;
         row_done = 1'b0;
         len_log2 = LOG2_RESET;
         coef_q.delete();
      end else begin
         if (csr_psel && csr_penable && csr_pready &&
             int'(csr_paddr) / 4 == int'(REG_LOG2_LENGTH)) begin
            if (csr_pwrite) begin
               len_log2 = csr_pwdata[CFG_BITS-1:0];
               fill_cnt = 0;
               rd_ptr   = 0;
               row_done = 1'b0;
            end else if (csr_prdata !== CSR_DATA_BITS'(len_log2)) begin
               flag("log2_length readback", len_log2, csr_prdata);
            end
         end

         if (rsp_mon.valid && rsp_mon.ready) begin
            if (coef_q.size() == 0) begin
               errs++;
               if (errs <= MAX_REPORTS)
                  $display("%0t ns: word expected none, got coefficient %0d status %0b",
                           $time, rsp_mon.coefficient, rsp_mon.status);
            end else begin
               want = coef_q.pop_front();
               checked++;
               if (rsp_mon.coefficient !== want.coefficient)
                  flag("coefficient", want.coefficient, rsp_mon.coefficient);
               if (rsp_mon.last_of_row !== want.last_of_row)
                  flag("last_of_row", want.last_of_row, rsp_mon.last_of_row);
               if (rsp_mon.status !== want.status)
                  flag("status", want.status, rsp_mon.status);
            end
         end

         if (req_mon.valid && req_mon.ready) begin
            n = row_points();
            if (req_mon.action == ACT_PUSH) begin
               // a finished row blocks new samples until it has been read out
               if (!row_done) begin
                  if (fill_cnt >= n) fill_cnt = 0;
                  row_mem[fill_cnt] = int'(req_mon.sample);
                  fill_cnt++;
                  if (fill_cnt == n) begin
                     run_butterflies(n);
                     fill_cnt = 0;
                     rd_ptr   = 0;
                     row_done = 1'b1;
                  end
               end
            end else if (!row_done || rd_ptr >= n) begin
               want.coefficient = '0;
               want.last_of_row = 1'b0;
               want.status      = STATUS_EMPTY;
               coef_q.push_back(want);
            end else begin
               want.coefficient = COEF_BITS'(row_mem[rd_ptr]);
               want.last_of_row = (rd_ptr == n - 1);
               want.status      = STATUS_VALID;
               coef_q.push_back(want);
               rd_ptr++;
               if (rd_ptr == n) begin
                  rd_ptr   = 0;
                  row_done = 1'b0;
               end
            end
         end
      end
      error_count   <= errs;
      pending_words <= coef_q.size();
      checked_words <= checked;
   end

endmodule

// File: tb/sv/tb_walsh_hadamard_transform_unit.sv
`timescale 1ns / 1ps
// Top of the Walsh-Hadamard transform unit testbench: clock, reset, stimulus and verdict.
// Depends on wht_pkg, wht_if, wht_coef_checker and walsh_hadamard_transform_unit.
module tb_walsh_hadamard_transform_unit;
   import wht_pkg::*;

   localparam int RANDOM_ITEMS    = 250;
   localparam int RSP_HOLD_CYCLES = 400;
   localparam int END_SETTLE      = 64;
   localparam int FINAL_LOG2      = 8;
   localparam logic [CSR_ADDR_BITS-1:0] LEN_ADDR = CSR_ADDR_BITS'(4 * int'(REG_LOG2_LENGTH));
   localparam logic [CSR_ADDR_BITS-1:0] PAST_LIST_ADDR =
      CSR_ADDR_BITS'(4 * (int'(REG_LOG2_LENGTH) + 1));
   localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
   localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};

   typedef enum int {FILL_RANDOM, FILL_EXTREME, FILL_MIN, FILL_MAX, FILL_SPARSE} fill_kind_type;

   logic                     clock;
   logic                     reset;
   logic                     csr_psel;
   logic                     csr_penable;
   logic                     csr_pwrite;
   logic [CSR_ADDR_BITS-1:0] csr_paddr;
   logic [CSR_DATA_BITS-1:0] csr_pwdata;
   logic [CSR_DATA_BITS-1:0] csr_prdata;
   logic                     csr_pready;
   int                       error_count;
   int                       pending_words;
   int                       checked_words;

   // stimulus-side view of the block state
   int len_k;
   int len_pts;
   int fill;
   int rd;
   bit row_waiting;
   int items;
   int pushes;
   int dropped;
   int pulls;
   int rows;
   int cfg_writes;
   bit tx_quiet;
   bit hold_rsp;
   bit hold_next;

   wht_req_if req_bus ();
   wht_rsp_if rsp_bus ();

   walsh_hadamard_transform_unit u_top (
      .clock       (clock),
      .reset       (reset),
      .req         (req_bus),
      .rsp         (rsp_bus),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   wht_coef_checker u_check (
      .clock         (clock),
      .reset         (reset),
      .req_mon       (req_bus),
      .rsp_mon       (rsp_bus),
      .csr_psel      (csr_psel),
      .csr_penable   (csr_penable),
      .csr_pwrite    (csr_pwrite),
      .csr_paddr     (csr_paddr),
      .csr_pwdata    (csr_pwdata),
      .csr_prdata    (csr_prdata),
      .csr_pready    (csr_pready),
      .error_count   (error_count),
      .pending_words (pending_words),
      .checked_words (checked_words)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   initial begin
      #60_000_000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   function automatic int pick_idle();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 40);
   endfunction

   function automatic int pick_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 40) return 5;
      if (r < 65) return 6;
      if (r < 78) return 7;
      if (r < 88) return $urandom_range(0, 4);
      return 7;
   endfunction

   function automatic fill_kind_type pick_kind();
      int r;
      r = $urandom_range(0, 9);
      if (r < 5) return FILL_RANDOM;
      if (r < 7) return FILL_EXTREME;
      if (r == 7) return FILL_MIN;
      if (r == 8) return FILL_MAX;
      return FILL_SPARSE;
   endfunction

   function automatic logic signed [SAMPLE_BITS-1:0] pick_sample(input fill_kind_type kind);
      logic signed [SAMPLE_BITS-1:0] s;
      s = SAMPLE_BITS'($urandom);
      case (kind)
         FILL_EXTREME: begin
            case ($urandom_range(0, 3))
               0: s = SAMPLE_MIN;
               1: s = SAMPLE_MAX;
               2: s = '0;
               default: s = '1;
            endcase
         end
         FILL_MIN: s = SAMPLE_MIN;
         FILL_MAX: s = SAMPLE_MAX;
         FILL_SPARSE: if ($urandom_range(0, 15) != 0) s = '0;
         default: ;
      endcase
      return s;
   endfunction

   // one request word; returns at the accepting edge or after the following gap
   task automatic send_word(input logic act, input logic signed [SAMPLE_BITS-1:0] smp);
      int gap;
      req_bus.valid  <= 1'b1;
      req_bus.action <= act;
      req_bus.sample <= smp;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      if (act == ACT_PUSH) begin
         pushes++;
         if (row_waiting) begin
            dropped++;
         end else begin
            items++;
            fill++;
            if (fill == len_pts) begin
               fill        = 0;
               rd          = 0;
               row_waiting = 1'b1;
               rows++;
            end
         end
      end else begin
         pulls++;
         items++;
         // the transform is over once a pull gets in, so a hold here stalls the pulls
         if (hold_next) begin
            hold_rsp  = 1'b1;
            hold_next = 1'b0;
         end
         if (row_waiting) begin
            rd++;
            if (rd == len_pts) begin
               rd          = 0;
               row_waiting = 1'b0;
            end
         end
      end
      gap = tx_quiet ? 0 : pick_idle();
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic push_row(input int count, input fill_kind_type kind);
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(0, 19) == 0) send_word(ACT_PULL, SAMPLE_BITS'($urandom));
         send_word(ACT_PUSH, pick_sample(kind));
      end
   endtask

   task automatic pull_row(input int count);
      for (int i = 0; i < count; i++) begin
         if (row_waiting && $urandom_range(0, 15) == 0)
            send_word(ACT_PUSH, SAMPLE_BITS'($urandom));
         send_word(ACT_PULL, SAMPLE_BITS'($urandom));
      end
   endtask

   task automatic csr_cycle(input logic wr, input logic [CSR_ADDR_BITS-1:0] addr,
                            input logic [CSR_DATA_BITS-1:0] data);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= wr;
      csr_paddr   <= addr;
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   // stop offering words, let every response come back, then cover a running transform
   task automatic drain();
      int settle;
      settle = (row_waiting && rd == 0) ? len_k * (len_pts + 1) + 8 : 8;
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (pending_words != 0) @(posedge clock);
      repeat (settle) @(posedge clock);
   endtask

   task automatic set_length(input int value);
      drain();
      csr_cycle(1'b1, LEN_ADDR,
                (CSR_DATA_BITS'($urandom) << CFG_BITS) | CSR_DATA_BITS'(value));
      csr_cycle(1'b0, LEN_ADDR, '0);
      len_k       = value < MIN_LOG2 ? MIN_LOG2 : (value > MAX_LOG2 ? MAX_LOG2 : value);
      len_pts     = 1 << len_k;
      fill        = 0;
      rd          = 0;
      row_waiting = 1'b0;
      cfg_writes++;
   endtask

   // response side: random bursts and gaps, plus a long hold-off on request
   initial begin
      int run_left;
      int idle_left;
      run_left  = 0;
      idle_left = 0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_rsp) begin
            hold_rsp = 1'b0;
            rsp_bus.ready <= 1'b0;
            repeat (RSP_HOLD_CYCLES) @(posedge clock);
         end else if (run_left > 0) begin
            run_left--;
            rsp_bus.ready <= 1'b1;
         end else if (idle_left > 0) begin
            idle_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            run_left  = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 200)
                                                    : $urandom_range(0, 15);
            idle_left = pick_idle();
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   initial begin
      int            phase_rows;
      bit            abandon;
      bit            first_hold;
      fill_kind_type kind;
      reset          <= 1'b1;
      req_bus.valid  <= 1'b0;
      req_bus.action <= ACT_PUSH;
      req_bus.sample <= '0;
      csr_psel       <= 1'b0;
      csr_penable    <= 1'b0;
      csr_pwrite     <= 1'b0;
      csr_paddr      <= '0;
      csr_pwdata     <= '0;
      hold_rsp    = 1'b0;
      hold_next   = 1'b0;
      tx_quiet    = 1'b0;
      first_hold  = 1'b1;
      len_k       = int'(LOG2_RESET);
      len_pts     = 1 << len_k;
      fill        = 0;
      rd          = 0;
      row_waiting = 1'b0;
      items       = 0;
      pushes      = 0;
      dropped     = 0;
      pulls       = 0;
      rows        = 0;
      cfg_writes  = 0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // directed: reset value, empty pulls, write past the register list,
      // extreme samples, clamped lengths and abandoned partial rows
      csr_cycle(1'b0, LEN_ADDR, '0);
      send_word(ACT_PULL, SAMPLE_MAX);
      send_word(ACT_PULL, SAMPLE_MIN);
      drain();
      csr_cycle(1'b1, PAST_LIST_ADDR, CSR_DATA_BITS'(6));
      csr_cycle(1'b0, LEN_ADDR, '0);
      send_word(ACT_PUSH, SAMPLE_MIN);
      send_word(ACT_PUSH, SAMPLE_MAX);
      send_word(ACT_PUSH, '0);
      send_word(ACT_PUSH, '1);
      send_word(ACT_PUSH, SAMPLE_BITS'(1));
      send_word(ACT_PUSH, SAMPLE_BITS'(16'h5555));
      send_word(ACT_PUSH, SAMPLE_BITS'(16'hAAAA));
      set_length(15);
      send_word(ACT_PULL, '0);
      send_word(ACT_PUSH, SAMPLE_MAX);
      send_word(ACT_PUSH, SAMPLE_MIN);
      send_word(ACT_PUSH, SAMPLE_MAX);
      set_length(0);

      items = 0;
      while (items < RANDOM_ITEMS) begin
         set_length(pick_length());
         tx_quiet   = ($urandom_range(0, 3) == 0);
         phase_rows = $urandom_range(1, 3);
         abandon    = 1'b0;
         for (int r = 0; r < phase_rows && !abandon && items < RANDOM_ITEMS; r++) begin
            kind = pick_kind();
            if ($urandom_range(0, 7) == 0) begin
               push_row($urandom_range(1, len_pts - 1), kind);
               abandon = 1'b1;
            end else begin
               push_row(len_pts, kind);
               if (first_hold || $urandom_range(0, 14) == 0) begin
                  hold_next  = 1'b1;
                  first_hold = 1'b0;
               end
               case ($urandom_range(0, 9))
                  0: begin
                     pull_row($urandom_range(1, len_pts - 1));
                     abandon = 1'b1;
                  end
                  1: pull_row(len_pts + $urandom_range(1, 3));
                  default: pull_row(len_pts);
               endcase
            end
         end
      end

      // 256-point row, all samples at the negative limit: largest magnitude of the run
      set_length(FINAL_LOG2);
      tx_quiet = 1'b0;
      push_row(len_pts, FILL_MIN);
      hold_next = 1'b1;
      pull_row(len_pts);

      drain();
      repeat (END_SETTLE) @(posedge clock);
      $display("Covered %0d pushes (%0d dropped on a waiting row) and %0d pulls over %0d rows",
               pushes, dropped, pulls, rows);
      $display("%0d length writes, rows of 32 up to %0d points, %0d response words checked",
               cfg_writes, 1 << FINAL_LOG2, checked_words);
      if (error_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

// File: sim.f
design/wht_pkg.sv
design/wht_if.sv
design/wht_row_ram.sv
design/walsh_hadamard_transform_unit.sv
tb/sv/wht_coef_checker.sv
tb/sv/tb_walsh_hadamard_transform_unit.sv
